[sv/dtq_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the delta timer queue.
`timescale 1ns / 1ps

package dtq_pkg;

  localparam int SLOT_W      = 4;
  localparam int NUM_TIMERS  = 1 << SLOT_W;
  localparam int CNT_W       = SLOT_W + 1;
  localparam int TICK_WIDTH  = 32;
  localparam int PARAM_WIDTH = 32;
  localparam int REQ_W       = 2;
  localparam int STAT_W      = 3;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 40;

  localparam logic [REQ_W-1:0] REQ_CREATE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_REJECT    = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_ARMED = 3'd2;
  localparam logic [STAT_W-1:0] ST_EXPIRED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NONE_DUE  = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic walk_step;
    logic walk_end;
    logic emit_single;
  } cmd_t;

  typedef struct packed {
    logic                  go_walk;
    logic                  walk_done;
    logic                  hit_emit;
    logic                  out_free;
    logic                  need_single;
    logic [NUM_TIMERS-1:0] armed;
    logic [CNT_W-1:0]      count;
  } stat_t;

endpackage

[sv/delta_timer_queue.sv]
// Top level of the delta timer queue: controller, datapath and checks.
//
//  channel | direction | tvalid/tready       | payload
//  --------+-----------+---------------------+---------------------------------------------
//  s_      | in        | s_tvalid / s_tready | tuser: req_type; tdata: slot, ticks, timer_param
//  m_      | out       | m_tvalid / m_tready | tuser: status; tdata: fired_slot, fired_param;
//          |           |                     | tlast: last
//
// One word is taken at a time. A create, an unknown request or a failed delete goes from
// execution straight to its single result. A delete that succeeds and a tick walk the
// creation-order list one entry a cycle over the N armed timers while the output has room,
// sending each expiry as it is met and then, where no expiry went out, a single result.
// A stalled output holds the walk on the next expiring entry; reset disarms every timer.
`timescale 1ns / 1ps

module delta_timer_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [3:0] slot, [35:4] ticks, [67:36] timer_param, [71:68] zero
  input  logic [dtq_pkg::IN_DATA_W-1:0]  s_tdata,
  // [1:0] req_type
  input  logic [dtq_pkg::REQ_W-1:0]      s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [3:0] fired_slot, [35:4] fired_param, [39:36] zero
  output logic [dtq_pkg::OUT_DATA_W-1:0] m_tdata,
  // [2:0] status
  output logic [dtq_pkg::STAT_W-1:0]     m_tuser,
  output logic                           m_tlast
);
  import dtq_pkg::*;

  cmd_t   cmd;
  stat_t  stat;
  state_t state;

  dtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  dtq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_tdata (s_tdata),
    .in_tuser (s_tuser),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Between requests the armed count matches the armed flags.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(stat.armed) == 32'(stat.count)))
    else $error("armed count out of step with armed flags");

  // Only an expiry carries a slot and parameter, and every other result ends its request.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_EXPIRED)) |-> (m_tlast && (m_tdata == '0)))
    else $error("non-expiry result with payload or without last");

  // An accepted word is executed in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EXEC))
    else $error("accepted word not executed");

endmodule

[sv/dtq_ctrl.sv]
// Controller state machine that sequences request execution, the order walk and result output.
`timescale 1ns / 1ps

module dtq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  dtq_pkg::stat_t stat,
  output dtq_pkg::cmd_t  cmd,
  output dtq_pkg::state_t state
);
  import dtq_pkg::*;

  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = stat.go_walk ? S_WALK : S_EMIT;
      end
      S_WALK: begin
        if (stat.walk_done) state_next = stat.need_single ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready        = 1'b0;
    cmd             = '0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_WALK: begin
        // An expiring entry can only move on once the output register has room.
        cmd.walk_step = !stat.walk_done && (!stat.hit_emit || stat.out_free);
        cmd.walk_end  = stat.walk_done;
      end
      S_EMIT: begin
        cmd.emit_single = stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

[sv/dtq_datapath.sv]
// Timer storage, creation-order list, walk counters and the output register.
`timescale 1ns / 1ps

module dtq_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  dtq_pkg::cmd_t                    cmd,
  input  logic [dtq_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [dtq_pkg::REQ_W-1:0]        in_tuser,
  output dtq_pkg::stat_t                   stat,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [dtq_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [dtq_pkg::STAT_W-1:0]       m_tuser,
  output logic                             m_tlast
);
  import dtq_pkg::*;

  logic [REQ_W-1:0]       req;
  logic [SLOT_W-1:0]      req_slot;
  logic [TICK_WIDTH-1:0]  req_ticks;
  logic [PARAM_WIDTH-1:0] req_param;

  logic [TICK_WIDTH-1:0]  remaining   [NUM_TIMERS];
  logic [PARAM_WIDTH-1:0] param_store [NUM_TIMERS];
  // order_list[r] is the slot of the armed timer with creation rank r.
  logic [SLOT_W-1:0]      order_list  [NUM_TIMERS];

  logic [NUM_TIMERS-1:0]  armed;
  logic [NUM_TIMERS-1:0]  drop;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       len;
  logic [CNT_W-1:0]       rd;
  logic [CNT_W-1:0]       wr;
  logic                   emitted_any;
  logic [STAT_W-1:0]      pend_status;

  logic                   out_valid;
  logic [STAT_W-1:0]      out_status;
  logic [SLOT_W-1:0]      out_slot;
  logic [PARAM_WIDTH-1:0] out_param;
  logic                   out_last;

  logic                   create_ok;
  logic                   delete_ok;
  logic                   is_tick;
  logic [SLOT_W-1:0]      cur_slot;
  logic                   hit;
  logic [NUM_TIMERS-1:0]  rest_drop;
  logic                   walk_emit;
  logic                   out_free;

  assign create_ok = (req_ticks != '0) && !armed[req_slot];
  assign delete_ok = armed[req_slot];
  assign is_tick   = (req == REQ_TICK);
  assign cur_slot  = order_list[rd[SLOT_W-1:0]];
  assign hit       = drop[cur_slot];
  assign rest_drop = drop & ~(NUM_TIMERS'(1) << cur_slot);
  assign walk_emit = cmd.walk_step && hit && is_tick;
  assign out_free  = !out_valid || m_tready;

  assign stat.go_walk     = is_tick || ((req == REQ_DELETE) && delete_ok);
  assign stat.walk_done   = (rd == len);
  assign stat.hit_emit    = hit && is_tick;
  assign stat.out_free    = out_free;
  assign stat.need_single = !emitted_any;
  assign stat.armed       = armed;
  assign stat.count       = count;

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_DATA_W - PARAM_WIDTH - SLOT_W)'(0), out_param, out_slot};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (req)
          REQ_CREATE: begin
            if (create_ok) begin
              armed[req_slot] <= 1'b1;
              count           <= count + CNT_W'(1);
            end
          end
          REQ_DELETE: begin
            if (delete_ok) armed[req_slot] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (walk_emit) armed[cur_slot] <= 1'b0;
      // The walk compacts the order list, so its write pointer is the new count.
      if (cmd.walk_end) count <= wr;
      if (cmd.emit_single || walk_emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req       <= in_tuser;
      req_slot  <= in_tdata[SLOT_W-1:0];
      req_ticks <= in_tdata[SLOT_W +: TICK_WIDTH];
      req_param <= in_tdata[SLOT_W + TICK_WIDTH +: PARAM_WIDTH];
    end

    if (cmd.exec) begin
      rd          <= '0;
      wr          <= '0;
      len         <= count;
      emitted_any <= 1'b0;
      case (req)
        REQ_CREATE: begin
          pend_status <= create_ok ? ST_OK : ST_REJECT;
          if (create_ok) begin
            remaining[req_slot]              <= req_ticks;
            param_store[req_slot]            <= req_param;
            order_list[count[SLOT_W-1:0]]    <= req_slot;
          end
        end
        REQ_DELETE: begin
          pend_status <= delete_ok ? ST_OK : ST_NOT_ARMED;
          drop        <= NUM_TIMERS'(1) << req_slot;
        end
        REQ_TICK: begin
          pend_status <= ST_NONE_DUE;
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (armed[i] && (remaining[i] != '0)) begin
              remaining[i] <= remaining[i] - TICK_WIDTH'(1);
            end
            // A count of one (or zero) reaches zero on this tick.
            drop[i] <= armed[i] && (remaining[i] <= TICK_WIDTH'(1));
          end
        end
        default: begin
          pend_status <= ST_REJECT;
        end
      endcase
    end

    if (cmd.walk_step) begin
      rd <= rd + CNT_W'(1);
      if (hit) begin
        drop[cur_slot] <= 1'b0;
        if (is_tick) emitted_any <= 1'b1;
      end else begin
        order_list[wr[SLOT_W-1:0]] <= cur_slot;
        wr                         <= wr + CNT_W'(1);
      end
    end

    if (cmd.emit_single) begin
      out_status <= pend_status;
      out_slot   <= '0;
      out_param  <= '0;
      out_last   <= 1'b1;
    end else if (walk_emit) begin
      out_status <= ST_EXPIRED;
      out_slot   <= cur_slot;
      out_param  <= param_store[cur_slot];
      out_last   <= (rest_drop == '0);
    end
  end

endmodule
